>>> src/pcxd_pkg.sv
// Shared types, constants and helpers of the PCX run-length palette decoder.
`default_nettype none

package pcxd_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int DIM_W           = 17;
    localparam int POS_W           = 16;
    localparam int COUNT_W         = 6;
    localparam int REG_IDX_W       = 1;

    localparam logic [7:0]         RUN_MARK   = 8'hC0;
    localparam logic [COUNT_W-1:0] COUNT_MASK = 6'h3F;
    localparam logic [7:0]         OPAQUE     = 8'hFF;
    localparam logic [DIM_W-1:0]   MAX_DIM    = 17'h10000;

    typedef enum logic [1:0] {
        CMD_PAL_WRITE = 2'd0,
        CMD_DATA      = 2'd1,
        CMD_END       = 2'd2,
        CMD_START     = 2'd3
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] entry_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] coded_byte;
    } coded_t;

    typedef struct packed {
        logic [7:0]       pixel_red;
        logic [7:0]       pixel_green;
        logic [7:0]       pixel_blue;
        logic [7:0]       pixel_alpha;
        logic [7:0]       color_index;
        logic [POS_W-1:0] start_column;
        logic [POS_W-1:0] row_number;
        logic [DIM_W-1:0] run_length;
        logic             is_padding;
        logic             image_done;
    } pixel_t;

    // One unit of work for the back end: a palette write or a run to colour.
    typedef struct packed {
        logic              is_write;
        logic [PAL_AW-1:0] index;
        logic [23:0]       rgb;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic [DIM_W-1:0]  length;
        logic              pad;
        logic              done;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_slot_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        end
        else if (v > MAX_DIM)
        begin
            r = MAX_DIM;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/pcxd_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
`default_nettype none

interface pcxd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/pcx_rle_palette_decoder.sv
// Top level of the PCX run-length palette decoder.
//
// Input channel "coded" carries command items: palette writes, coded data
// bytes, end of data and start of image. Output channel "pixels" carries one
// item per decoded run: its RGBA colour, palette index, column, row, length
// and the padding and image-done flags. Both use valid/ready; a transfer
// happens on a clock edge with both high.
// Image width and height are written through wr_en/wr_index/wr_data; the user
// must write them only while the block is idle, which the block itself does not
// enforce. Reset leaves both at one. Throughput: one input item per cycle while
// the job queue is not full. A run passes through the job queue, the registered
// palette lookup and the output register before it appears on pixels.valid.
// When the receiver stalls, the output register, lookup stage and the job
// queue (QUEUE_DEPTH entries) fill; coded.ready drops only once the queue
// is full. Reset empties the pipeline and clears the decode position; palette
// contents are undefined until written.
`default_nettype none

module pcx_rle_palette_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [pcxd_pkg::REG_IDX_W-1:0] wr_index,
    input  wire logic [pcxd_pkg::DIM_W-1:0]     wr_data,
    pcxd_stream_if.sink                         coded,
    pcxd_stream_if.source                       pixels
);

    pcxd_pkg::q_slot_t push, head;
    logic              full, pop;

    pcxd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .coded    (coded),
        .push     (push),
        .full     (full)
    );

    pcxd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    pcxd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .pixels (pixels)
    );

endmodule

`default_nettype wire

>>> src/pcxd_front.sv
// Front end: configuration registers, item classification and run position tracking.
`default_nettype none

module pcxd_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [pcxd_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [pcxd_pkg::DIM_W-1:0]      wr_data,
    pcxd_stream_if.sink                          coded,
    output pcxd_pkg::q_slot_t                    push,
    input  wire logic                            full
);

    logic [pcxd_pkg::DIM_W-1:0]   width_reg, height_reg;
    logic [pcxd_pkg::DIM_W-1:0]   col_reg, col_next;
    logic [pcxd_pkg::DIM_W-1:0]   row_reg, row_next;
    logic                         pend_reg, pend_next;
    logic [pcxd_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                         fin_reg, fin_next;
    logic                         started_reg, started_next;

    logic [pcxd_pkg::DIM_W-1:0]   w, h;
    logic                         accept;
    pcxd_pkg::cmd_t               cmd;
    logic [7:0]                   byte_in;
    logic                         row_live, wrap;
    logic [pcxd_pkg::DIM_W-1:0]   row_inc, c, r, span, rn;
    logic                         st, live;
    logic [pcxd_pkg::DIM_W:0]     sum, newcol;
    logic                         emit, pad, rowdone, done;
    logic [pcxd_pkg::DIM_W-1:0]   len;
    logic [7:0]                   idx;

    assign w       = pcxd_pkg::clamp_dim(width_reg);
    assign h       = pcxd_pkg::clamp_dim(height_reg);
    assign coded.ready = !full;
    assign accept  = coded.valid && !full;
    assign cmd     = pcxd_pkg::cmd_t'(coded.data.command);
    assign byte_in = coded.data.coded_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= {{(pcxd_pkg::DIM_W-1){1'b0}}, 1'b1};
            height_reg <= {{(pcxd_pkg::DIM_W-1){1'b0}}, 1'b1};
        end
        else if (wr_en)
        begin
            case (pcxd_pkg::reg_idx_t'(wr_index))
                pcxd_pkg::REG_IMAGE_WIDTH:  width_reg  <= wr_data;
                pcxd_pkg::REG_IMAGE_HEIGHT: height_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Settle the position first: a row that is already full wraps before use.
    assign row_live = row_reg < h;
    assign wrap     = col_reg >= w;
    assign row_inc  = row_reg + 1'b1;
    assign c        = wrap ? '0 : col_reg;
    assign r        = wrap ? row_inc : row_reg;
    assign st       = wrap ? 1'b0 : started_reg;
    assign live     = row_live && (r < h);
    assign sum      = {1'b0, c} + {{(pcxd_pkg::DIM_W+1-pcxd_pkg::COUNT_W){1'b0}}, cnt_reg};
    assign span     = w - c;
    assign rn       = r + 1'b1;

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        pend_next    = pend_reg;
        cnt_next     = cnt_reg;
        fin_next     = fin_reg;
        started_next = started_reg;
        emit         = 1'b0;
        pad          = 1'b0;
        len          = {{(pcxd_pkg::DIM_W-1){1'b0}}, 1'b1};
        idx          = byte_in;
        newcol       = '0;
        rowdone      = 1'b0;
        done         = 1'b0;
        push         = '0;

        if (accept)
        begin
            case (cmd)
                pcxd_pkg::CMD_PAL_WRITE:
                begin
                    push.valid        = 1'b1;
                    push.job.is_write = 1'b1;
                    push.job.index    = coded.data.entry_index;
                    push.job.rgb      = {coded.data.entry_red, coded.data.entry_green,
                                         coded.data.entry_blue};
                end
                pcxd_pkg::CMD_START:
                begin
                    col_next     = '0;
                    row_next     = '0;
                    pend_next    = 1'b0;
                    cnt_next     = '0;
                    fin_next     = 1'b0;
                    started_next = 1'b0;
                end
                pcxd_pkg::CMD_DATA, pcxd_pkg::CMD_END:
                begin
                    if (!fin_reg)
                    begin
                        if (!row_live)
                        begin
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            col_next     = c;
                            row_next     = r;
                            started_next = st;
                            if (!live)
                            begin
                                fin_next = 1'b1;
                            end
                            else if (cmd == pcxd_pkg::CMD_DATA)
                            begin
                                started_next = 1'b1;
                                if (pend_reg)
                                begin
                                    // Clip the armed run at the row end; drop a zero count.
                                    pend_next = 1'b0;
                                    cnt_next  = '0;
                                    emit      = cnt_reg != '0;
                                    len       = (sum > {1'b0, w}) ? span :
                                        {{(pcxd_pkg::DIM_W-pcxd_pkg::COUNT_W){1'b0}}, cnt_reg};
                                end
                                else if (byte_in >= pcxd_pkg::RUN_MARK)
                                begin
                                    pend_next = 1'b1;
                                    cnt_next  = byte_in[pcxd_pkg::COUNT_W-1:0]
                                                & pcxd_pkg::COUNT_MASK;
                                end
                                else
                                begin
                                    emit = 1'b1;
                                end
                            end
                            else
                            begin
                                // End of data: pad a started row with entry zero.
                                pend_next = 1'b0;
                                cnt_next  = '0;
                                fin_next  = 1'b1;
                                emit      = (c != '0) || st;
                                pad       = 1'b1;
                                len       = span;
                                idx       = '0;
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (emit)
            begin
                newcol           = {1'b0, c} + {1'b0, len};
                rowdone          = newcol >= {1'b0, w};
                done             = rowdone && (rn >= h);
                push.valid       = 1'b1;
                push.job.index   = idx;
                push.job.column  = c[pcxd_pkg::POS_W-1:0];
                push.job.row     = r[pcxd_pkg::POS_W-1:0];
                push.job.length  = len;
                push.job.pad     = pad;
                push.job.done    = done;
                if (rowdone)
                begin
                    col_next     = '0;
                    row_next     = rn;
                    started_next = 1'b0;
                    if (done)
                    begin
                        fin_next = 1'b1;
                    end
                end
                else
                begin
                    col_next = newcol[pcxd_pkg::DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            fin_reg     <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            fin_reg     <= fin_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

>>> src/pcxd_fifo.sv
// Short job queue between the front and back ends.
`default_nettype none

module pcxd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcxd_pkg::q_slot_t push,
    output logic                   full,
    output pcxd_pkg::q_slot_t      head,
    input  wire logic              pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    pcxd_pkg::job_t slots [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push, do_pop;

    assign full       = count_reg == FULL_COUNT;
    assign head.valid = count_reg != '0;
    assign head.job   = slots[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/pcxd_back.sv
// Back end: palette memory, colour lookup and the output register.
`default_nettype none

module pcxd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcxd_pkg::q_slot_t head,
    output logic                   pop,
    pcxd_stream_if.source          pixels
);

    logic [23:0]    palette_mem [pcxd_pkg::PALETTE_ENTRIES];
    logic [23:0]    rd_reg;
    logic           s1_valid_reg;
    pcxd_pkg::job_t s1_job_reg;
    logic           out_valid_reg;
    pcxd_pkg::pixel_t out_reg;

    logic out_free, s1_free, take_write, take_run;

    assign out_free   = !out_valid_reg || pixels.ready;
    assign s1_free    = !s1_valid_reg || out_free;
    // Palette writes never wait; runs wait for the lookup stage.
    assign take_write = head.valid && head.job.is_write;
    assign take_run   = head.valid && !head.job.is_write && s1_free;
    assign pop        = take_write || take_run;

    assign pixels.valid = out_valid_reg;
    assign pixels.data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (take_write)
        begin
            palette_mem[head.job.index] <= head.job.rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_run)
        begin
            rd_reg     <= palette_mem[head.job.index];
            s1_job_reg <= head.job;
        end
        if (s1_valid_reg && out_free)
        begin
            out_reg.pixel_red    <= rd_reg[23:16];
            out_reg.pixel_green  <= rd_reg[15:8];
            out_reg.pixel_blue   <= rd_reg[7:0];
            out_reg.pixel_alpha  <= pcxd_pkg::OPAQUE;
            out_reg.color_index  <= s1_job_reg.index;
            out_reg.start_column <= s1_job_reg.column;
            out_reg.row_number   <= s1_job_reg.row;
            out_reg.run_length   <= s1_job_reg.length;
            out_reg.is_padding   <= s1_job_reg.pad;
            out_reg.image_done   <= s1_job_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= take_run;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/pcxd_checker.sv
// Port-level checks of the decoder's output channel, bound to the top level.
`default_nettype none

module pcxd_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire pcxd_pkg::pixel_t out_data
);

    // Hold a stalled result unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or vanished");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.pixel_alpha == pcxd_pkg::OPAQUE)
        else $error("alpha not opaque");

    // A run is never empty and never runs past the widest row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.run_length != '0 &&
            ({2'b00, out_data.start_column} + {1'b0, out_data.run_length})
                <= {1'b0, pcxd_pkg::MAX_DIM})
        else $error("run length out of range");

endmodule

bind pcx_rle_palette_decoder pcxd_checker u_pcxd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready),
    .out_data  (pixels.data)
);

`default_nettype wire

>>> tb/pcx_rle_palette_decoder_tb.sv
// Self-checking testbench for the PCX run-length palette decoder.
`timescale 1ns / 100ps

module pcx_rle_palette_decoder_tb;

    localparam int MAX_GAP       = 8;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 680;
    localparam int CYCLE_LIMIT   = 400000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           wr_en;
    logic [pcxd_pkg::REG_IDX_W-1:0] wr_index;
    logic [pcxd_pkg::DIM_W-1:0]     wr_data;

    pcxd_stream_if #(.payload_t(pcxd_pkg::coded_t)) coded_ch ();
    pcxd_stream_if #(.payload_t(pcxd_pkg::pixel_t)) pixels_ch ();

    pcx_rle_palette_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .coded    (coded_ch),
        .pixels   (pixels_ch)
    );

    always #10 clk = ~clk;

    // Decoder state as predicted on this side
    logic [23:0]                  palette [pcxd_pkg::PALETTE_ENTRIES];
    logic [pcxd_pkg::DIM_W-1:0]   cfg_width   = 17'd1;
    logic [pcxd_pkg::DIM_W-1:0]   cfg_height  = 17'd1;
    logic                         run_armed   = 1'b0;
    logic [pcxd_pkg::COUNT_W-1:0] armed_count = '0;
    logic [pcxd_pkg::DIM_W-1:0]   cur_col     = '0;
    logic [pcxd_pkg::DIM_W-1:0]   cur_row     = '0;
    logic                         image_over  = 1'b0;
    logic                         row_open    = 1'b0;

    pcxd_pkg::coded_t coded_backlog [$];
    pcxd_pkg::pixel_t runs_due [$];

    int  items_sent    = 0;
    int  items_taken   = 0;
    int  runs_seen     = 0;
    int  pads_seen     = 0;
    int  frames_done   = 0;
    int  mismatches    = 0;
    int  settings_used = 0;
    int  cycle_count   = 0;
    int  long_hold_req = 0;
    int  long_hold_ack;
    int  tx_wait;
    int  rx_hold;
    int  rx_gap;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;

    function automatic logic [pcxd_pkg::DIM_W-1:0] fit_dim(
        input logic [pcxd_pkg::DIM_W-1:0] v);
        if (v == '0)
            return 17'd1;
        if (v > pcxd_pkg::MAX_DIM)
            return pcxd_pkg::MAX_DIM;
        return v;
    endfunction

    function automatic void advance_row(input logic [pcxd_pkg::DIM_W-1:0] h);
        cur_col  = '0;
        cur_row  = cur_row + 1'b1;
        row_open = 1'b0;
        if (cur_row >= h)
            image_over = 1'b1;
    endfunction

    function automatic void emit_run(input logic [7:0] idx,
                                     input logic [pcxd_pkg::DIM_W-1:0] len,
                                     input logic pad,
                                     input logic [pcxd_pkg::DIM_W-1:0] w,
                                     input logic [pcxd_pkg::DIM_W-1:0] h);
        pcxd_pkg::pixel_t due;
        due.pixel_red    = palette[idx][23:16];
        due.pixel_green  = palette[idx][15:8];
        due.pixel_blue   = palette[idx][7:0];
        due.pixel_alpha  = pcxd_pkg::OPAQUE;
        due.color_index  = idx;
        due.start_column = cur_col[pcxd_pkg::POS_W-1:0];
        due.row_number   = cur_row[pcxd_pkg::POS_W-1:0];
        due.run_length   = len;
        due.is_padding   = pad;
        due.image_done   = 1'b0;
        cur_col = cur_col + len;
        if (cur_col >= w)
        begin
            advance_row(h);
            due.image_done = image_over;
        end
        runs_due.push_back(due);
    endfunction

    // Returns 0 when the item is dropped because the image is already over.
    function automatic bit decode_item(input pcxd_pkg::coded_t item);
        logic [pcxd_pkg::DIM_W-1:0] w;
        logic [pcxd_pkg::DIM_W-1:0] h;
        logic [pcxd_pkg::DIM_W-1:0] stop;
        logic [pcxd_pkg::DIM_W-1:0] len;
        w = fit_dim(cfg_width);
        h = fit_dim(cfg_height);
        case (item.command)
            pcxd_pkg::CMD_PAL_WRITE:
            begin
                palette[item.entry_index] = {item.entry_red, item.entry_green,
                                             item.entry_blue};
                return 1'b1;
            end
            pcxd_pkg::CMD_START:
            begin
                run_armed   = 1'b0;
                armed_count = '0;
                cur_col     = '0;
                cur_row     = '0;
                image_over  = 1'b0;
                row_open    = 1'b0;
                return 1'b1;
            end
            default:
            begin
            end
        endcase
        if (image_over)
            return 1'b0;
        // a size change may have left the position past the row or the image
        if (cur_row >= h)
            image_over = 1'b1;
        else if (cur_col >= w)
            advance_row(h);
        if (image_over)
            return 1'b0;
        if (item.command == pcxd_pkg::CMD_DATA)
        begin
            row_open = 1'b1;
            if (run_armed)
            begin
                stop = cur_col + pcxd_pkg::DIM_W'(armed_count);
                if (stop > w)
                    stop = w;
                len         = stop - cur_col;
                run_armed   = 1'b0;
                armed_count = '0;
                if (len != '0)
                    emit_run(item.coded_byte, len, 1'b0, w, h);
            end
            else if (item.coded_byte >= pcxd_pkg::RUN_MARK)
            begin
                run_armed   = 1'b1;
                armed_count = item.coded_byte[pcxd_pkg::COUNT_W-1:0] & pcxd_pkg::COUNT_MASK;
            end
            else
                emit_run(item.coded_byte, 17'd1, 1'b0, w, h);
        end
        else
        begin
            run_armed   = 1'b0;
            armed_count = '0;
            if (cur_col != '0 || row_open)
                emit_run(8'd0, w - cur_col, 1'b1, w, h);
            image_over = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_run(input pcxd_pkg::pixel_t got);
        pcxd_pkg::pixel_t want;
        runs_seen++;
        if (runs_due.size() == 0)
        begin
            $error("run_length: expected no run, actual %0d at row %0d column %0d",
                   got.run_length, got.row_number, got.start_column);
            mismatches++;
            return;
        end
        want = runs_due.pop_front();
        compare_field("pixel_red", 32'(want.pixel_red), 32'(got.pixel_red));
        compare_field("pixel_green", 32'(want.pixel_green), 32'(got.pixel_green));
        compare_field("pixel_blue", 32'(want.pixel_blue), 32'(got.pixel_blue));
        compare_field("pixel_alpha", 32'(want.pixel_alpha), 32'(got.pixel_alpha));
        compare_field("color_index", 32'(want.color_index), 32'(got.color_index));
        compare_field("start_column", 32'(want.start_column), 32'(got.start_column));
        compare_field("row_number", 32'(want.row_number), 32'(got.row_number));
        compare_field("run_length", 32'(want.run_length), 32'(got.run_length));
        compare_field("is_padding", 32'(want.is_padding), 32'(got.is_padding));
        compare_field("image_done", 32'(want.image_done), 32'(got.image_done));
        if (want.is_padding)
            pads_seen++;
        if (want.image_done)
            frames_done++;
    endfunction

    function automatic int draw_gap(inout bit calm);
        // switch now and then between idling and back-to-back stretches
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Sender: present backlog items, predict each one on its transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coded_ch.valid <= 1'b0;
            coded_ch.data  <= '0;
            tx_wait        <= 0;
        end
        else
        begin
            if (coded_ch.valid && coded_ch.ready)
            begin
                items_sent++;
                if (decode_item(coded_ch.data))
                    items_taken++;
            end
            if (!coded_ch.valid || coded_ch.ready)
            begin
                if (tx_wait != 0)
                begin
                    tx_wait        <= tx_wait - 1;
                    coded_ch.valid <= 1'b0;
                end
                else if (coded_backlog.size() != 0)
                begin
                    coded_ch.data  <= coded_backlog.pop_front();
                    coded_ch.valid <= 1'b1;
                    tx_wait        <= draw_gap(tx_calm);
                end
                else
                    coded_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each run transfer, stall at random or on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_ch.ready <= 1'b0;
            rx_hold         <= 0;
            long_hold_ack   <= 0;
        end
        else
        begin
            if (pixels_ch.valid && pixels_ch.ready)
                check_run(pixels_ch.data);
            if (long_hold_ack != long_hold_req)
            begin
                long_hold_ack   <= long_hold_req;
                rx_hold         <= LONG_HOLD;
                pixels_ch.ready <= 1'b0;
            end
            else if (pixels_ch.valid && pixels_ch.ready)
            begin
                rx_gap = draw_gap(rx_calm);
                rx_hold         <= (rx_gap == 0) ? 0 : rx_gap - 1;
                pixels_ch.ready <= (rx_gap == 0);
            end
            else if (rx_hold != 0)
                rx_hold <= rx_hold - 1;
            else
                pixels_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void queue_item(input pcxd_pkg::cmd_t cmd, input logic [7:0] value);
        pcxd_pkg::coded_t item;
        item.command     = cmd;
        item.entry_index = 8'($urandom);
        item.entry_red   = 8'($urandom);
        item.entry_green = 8'($urandom);
        item.entry_blue  = 8'($urandom);
        item.coded_byte  = 8'($urandom);
        if (cmd == pcxd_pkg::CMD_PAL_WRITE)
            item.entry_index = value;
        else
            item.coded_byte = value;
        coded_backlog.push_back(item);
    endfunction

    // One image: mostly runs and single pixels, a little noise, usually closed
    function automatic void queue_image();
        int r;
        queue_item(pcxd_pkg::CMD_START, 8'($urandom));
        repeat ($urandom_range(3, 24))
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                queue_item(pcxd_pkg::CMD_PAL_WRITE, 8'($urandom));
            else if (r < 40)
            begin
                queue_item(pcxd_pkg::CMD_DATA,
                           pcxd_pkg::RUN_MARK | 8'($urandom_range(0, 63)));
                queue_item(pcxd_pkg::CMD_DATA, 8'($urandom));
            end
            else if (r < 97)
                queue_item(pcxd_pkg::CMD_DATA, 8'($urandom_range(0, 191)));
            else
                queue_item(pcxd_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0)
            queue_item(pcxd_pkg::CMD_END, 8'($urandom));
    endfunction

    function automatic logic [pcxd_pkg::DIM_W-1:0] pick_dim(input int typical);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return pcxd_pkg::DIM_W'($urandom_range(65536, 131071));
        return pcxd_pkg::DIM_W'($urandom_range(1, typical));
    endfunction

    task automatic write_reg(input pcxd_pkg::reg_idx_t idx,
                             input logic [pcxd_pkg::DIM_W-1:0] value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == pcxd_pkg::REG_IMAGE_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
    endtask

    task automatic set_size(input logic [pcxd_pkg::DIM_W-1:0] w,
                            input logic [pcxd_pkg::DIM_W-1:0] h);
        write_reg(pcxd_pkg::REG_IMAGE_WIDTH, w);
        write_reg(pcxd_pkg::REG_IMAGE_HEIGHT, h);
        settings_used++;
        @(negedge clk);
    endtask

    // Hold until every item has gone in and every run has come out
    task automatic drain();
        do
            @(negedge clk);
        while (coded_backlog.size() != 0 || coded_ch.valid || runs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int random_base;
        wr_en           = 1'b0;
        wr_index        = pcxd_pkg::REG_IMAGE_WIDTH;
        wr_data         = '0;
        rst_n           = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_size(17'd6, 17'd3);
        for (int e = 0; e < pcxd_pkg::PALETTE_ENTRIES; e++)
            queue_item(pcxd_pkg::CMD_PAL_WRITE, 8'(e));

        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'hBF);
        queue_item(pcxd_pkg::CMD_PAL_WRITE, 8'h07);
        // zero-count run eats its index byte
        queue_item(pcxd_pkg::CMD_DATA, 8'hC0);
        queue_item(pcxd_pkg::CMD_DATA, 8'h55);
        // long run clipped at the row end, colour rewritten while armed
        queue_item(pcxd_pkg::CMD_DATA, 8'hFF);
        queue_item(pcxd_pkg::CMD_PAL_WRITE, 8'hFF);
        queue_item(pcxd_pkg::CMD_DATA, 8'hFF);
        queue_item(pcxd_pkg::CMD_DATA, 8'hC3);
        queue_item(pcxd_pkg::CMD_DATA, 8'h07);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        // data and end after end of data are dropped
        queue_item(pcxd_pkg::CMD_DATA, 8'h10);
        queue_item(pcxd_pkg::CMD_END, 8'hFF);
        // end with nothing started
        queue_item(pcxd_pkg::CMD_START, 8'hFF);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        // end with a run armed pads the row
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'hC2);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        // full image, then data past the last row
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'hFF);
        queue_item(pcxd_pkg::CMD_DATA, 8'h01);
        queue_item(pcxd_pkg::CMD_DATA, 8'hFF);
        queue_item(pcxd_pkg::CMD_DATA, 8'h02);
        queue_item(pcxd_pkg::CMD_DATA, 8'hFF);
        queue_item(pcxd_pkg::CMD_DATA, 8'h03);
        queue_item(pcxd_pkg::CMD_DATA, 8'h04);
        drain();

        // shrink the width and then the height under a half-decoded image
        set_size(17'd8, 17'd4);
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'hC4);
        queue_item(pcxd_pkg::CMD_DATA, 8'h09);
        drain();
        set_size(17'd2, 17'd4);
        queue_item(pcxd_pkg::CMD_DATA, 8'h0A);
        queue_item(pcxd_pkg::CMD_DATA, 8'h0B);
        drain();
        set_size(17'd2, 17'd1);
        queue_item(pcxd_pkg::CMD_DATA, 8'h0C);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        drain();

        // out-of-range and largest sizes
        set_size(17'd0, 17'h1FFFF);
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'h21);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        drain();
        set_size(17'h1FFFF, 17'h10000);
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'hC0);
        queue_item(pcxd_pkg::CMD_DATA, 8'h00);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'h05);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        drain();
        set_size(17'h10000, 17'd0);
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        queue_item(pcxd_pkg::CMD_DATA, 8'hFF);
        queue_item(pcxd_pkg::CMD_DATA, 8'h11);
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        drain();

        random_base = items_sent;

        // long receiver stall with the sender still offering
        set_size(17'd40, 17'd4);
        long_hold_req++;
        queue_item(pcxd_pkg::CMD_START, 8'h00);
        repeat (100)
            queue_item(pcxd_pkg::CMD_DATA, 8'($urandom_range(0, 191)));
        queue_item(pcxd_pkg::CMD_END, 8'h00);
        drain();

        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            set_size(pick_dim(24), pick_dim(6));
            repeat ($urandom_range(1, 4))
                queue_image();
            drain();
        end

        drain();
        $display("Checked %0d runs (%0d padding, %0d closing an image) from %0d transfers in",
                 runs_seen, pads_seen, frames_done, items_sent);
        $display("%0d transfers decoded; image size set %0d times, zero and oversize included",
                 items_taken, settings_used);
        if (mismatches == 0 && runs_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
src/pcxd_pkg.sv
src/pcxd_stream_if.sv
src/pcxd_front.sv
src/pcxd_fifo.sv
src/pcxd_back.sv
src/pcx_rle_palette_decoder.sv
src/pcxd_checker.sv
tb/pcx_rle_palette_decoder_tb.sv
